// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lcwf_pkg.sv
// ----------------------------------------------------------------------------
// lcwf_pkg
// Shared types, register indexes and fixed widths of the weight filter.
// ----------------------------------------------------------------------------
package lcwf_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SNAP_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REMOVAL_PREV_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REMOVAL_NOW_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_GAIN     = 3'd4;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_TARE    = 1'b1;

  localparam int SCALE_W    = 32;
  localparam int LIMIT_W    = 24;
  localparam int GAIN_W     = 16;
  localparam int GAIN_SHIFT = 16;
  localparam int SCALE_Q    = 30;
  localparam int WEIGHT_W   = 32;
  localparam int NET_W      = 25;
  localparam int SHOWN_W    = 26;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 32'sh8000_0000;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 32'sh7FFF_FFFF;

  localparam logic signed [SCALE_W-1:0] SCALE_RST     = -32'sd71940702;
  localparam logic [LIMIT_W-1:0]        ZERO_SNAP_RST = 24'd512;
  localparam logic [LIMIT_W-1:0]        REM_PREV_RST  = 24'd5120;
  localparam logic [LIMIT_W-1:0]        REM_NOW_RST   = 24'd2560;
  localparam logic [GAIN_W-1:0]         GAIN_RST      = 16'd19661;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic signed [SCALE_W-1:0] scale_factor;
    logic [LIMIT_W-1:0]        zero_snap_limit;
    logic [LIMIT_W-1:0]        removal_prev_limit;
    logic [LIMIT_W-1:0]        removal_now_limit;
    logic [GAIN_W-1:0]         smoothing_gain;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fr_stat_t;

  typedef struct packed {
    logic busy;
  } bk_stat_t;

endpackage

// File: rtl/core/lcwf_if.sv
// ----------------------------------------------------------------------------
// lcwf_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface lcwf_in_if #(parameter int SAMPLE_BITS = 24) ();
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [SAMPLE_BITS-1:0] raw_reading;

  modport source (output valid, op, raw_reading, input ready);
  modport sink   (input valid, op, raw_reading, output ready);
endinterface

interface lcwf_out_if import lcwf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [NET_W-1:0]    net_counts;
  logic signed [WEIGHT_W-1:0] weight;
  logic signed [WEIGHT_W-1:0] filtered_weight;
  logic signed [SHOWN_W-1:0]  shown_half_grams;

  modport source (output valid, net_counts, weight, filtered_weight, shown_half_grams,
                  input ready);
  modport sink   (input valid, net_counts, weight, filtered_weight, shown_half_grams,
                  output ready);
endinterface

// File: rtl/core/lcwf_front.sv
// ----------------------------------------------------------------------------
// lcwf_front
// Accepts input items, decodes the op and holds them in a short queue.
// ----------------------------------------------------------------------------
module lcwf_front import lcwf_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lcwf_in_if.sink                       in_if,
  output logic                          pop_valid,
  input  logic                          pop_ready,
  output logic                          pop_is_tare,
  output logic signed [SAMPLE_BITS-1:0] pop_raw,
  output fr_stat_t                      stat
);

  localparam int CNT_W = Q_PTR_W + 1;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic               tare_q_r [Q_DEPTH];
  logic signed [SAMPLE_BITS-1:0] raw_q_r [Q_DEPTH];
  logic               push;
  logic               pop;

  assign in_if.ready = (cnt_r != CNT_W'(Q_DEPTH));
  assign pop_valid   = (cnt_r != '0);
  assign pop_is_tare = tare_q_r[rd_ptr_r];
  assign pop_raw     = raw_q_r[rd_ptr_r];
  assign stat.full   = (cnt_r == CNT_W'(Q_DEPTH));
  assign stat.empty  = (cnt_r == '0);

  always_comb begin
    push       = in_if.valid && in_if.ready;
    pop        = pop_valid && pop_ready;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      tare_q_r[wr_ptr_r] <= (in_if.op == OP_TARE);
      raw_q_r[wr_ptr_r]  <= in_if.raw_reading;
    end
  end

endmodule

// File: rtl/core/lcwf_back.sv
// ----------------------------------------------------------------------------
// lcwf_back
// Sequencer that applies tare, scales to weight and runs the display filter.
// ----------------------------------------------------------------------------
module lcwf_back import lcwf_pkg::*; #(
  parameter int SAMPLE_BITS      = 24,
  parameter int WEIGHT_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  logic                          pop_is_tare,
  input  logic signed [SAMPLE_BITS-1:0] pop_raw,
  lcwf_out_if.source                    out_if,
  output bk_stat_t                      stat
);

  localparam int NB          = SAMPLE_BITS + 1;
  localparam int LO_W        = 16;
  localparam int HI_W        = NB - LO_W;
  localparam int PW          = NB + SCALE_W;
  localparam int SCALE_SHIFT = SCALE_Q - WEIGHT_FRAC_BITS;
  localparam int WM_RAW      = PW + 1 - SCALE_SHIFT;
  localparam int WM_W        = (WM_RAW > WEIGHT_W + 1) ? WM_RAW : WEIGHT_W + 1;
  localparam int DIFF_W      = WEIGHT_W + 1;
  localparam int GP_W        = DIFF_W + GAIN_W + 1;
  localparam int Q_W         = GP_W - GAIN_SHIFT;
  localparam int SHOWN_SHIFT = WEIGHT_FRAC_BITS - 1;

  localparam logic [PW:0]                W_BIAS      = (PW + 1)'(2 ** (SCALE_SHIFT - 1));
  localparam logic [WM_W-1:0]            WM_NEG_LIM  = WM_W'(64'h8000_0000);
  localparam logic [WM_W-1:0]            WM_POS_LIM  = WM_W'(64'h7FFF_FFFF);
  localparam logic signed [GP_W-1:0]     G_BIAS_POS  = GP_W'(2 ** (GAIN_SHIFT - 1));
  localparam logic signed [GP_W-1:0]     G_BIAS_NEG  = GP_W'(2 ** (GAIN_SHIFT - 1) - 1);
  localparam logic signed [WEIGHT_W:0]   SH_BIAS_POS = (WEIGHT_W + 1)'(2 ** (SHOWN_SHIFT - 1));
  localparam logic signed [WEIGHT_W:0]   SH_BIAS_NEG =
    (WEIGHT_W + 1)'(2 ** (SHOWN_SHIFT - 1) - 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MAG  = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_SUM  = 4'd3;
  localparam logic [3:0] ST_WGT  = 4'd4;
  localparam logic [3:0] ST_DIF  = 4'd5;
  localparam logic [3:0] ST_GMUL = 4'd6;
  localparam logic [3:0] ST_GRND = 4'd7;
  localparam logic [3:0] ST_UPD  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [3:0]                    state_r;
  logic signed [SAMPLE_BITS-1:0] tare_r;
  logic signed [WEIGHT_W-1:0]    disp_r;
  logic signed [WEIGHT_W-1:0]    prev_r;
  logic signed [NB-1:0]          net_r;
  logic [NB-1:0]                 nmag_r;
  logic [SCALE_W-1:0]            smag_r;
  logic                          neg_r;
  logic [LO_W+SCALE_W-1:0]       plo_r;
  logic [HI_W+SCALE_W-1:0]       phi_r;
  logic [PW-1:0]                 pmag_r;
  logic signed [WEIGHT_W-1:0]    weight_r;
  logic                          snap_r;
  logic signed [DIFF_W-1:0]      diff_r;
  logic signed [GP_W-1:0]        gprod_r;
  logic signed [Q_W-1:0]         q_r;
  logic                          out_valid_r;
  logic signed [NET_W-1:0]       out_net_r;
  logic signed [WEIGHT_W-1:0]    out_weight_r;
  logic signed [WEIGHT_W-1:0]    out_filt_r;
  logic signed [SHOWN_W-1:0]     out_shown_r;

  logic [NB-1:0]              nmag_nxt;
  logic [SCALE_W-1:0]         smag_nxt;
  logic [PW:0]                wsum;
  logic [WM_W-1:0]            wmag;
  logic signed [WEIGHT_W-1:0] weight_nxt;
  logic [WEIGHT_W-1:0]        absw;
  logic [WEIGHT_W-1:0]        absp;
  logic                       snap_nxt;
  logic signed [GP_W-1:0]     gsum;
  logic signed [WEIGHT_W:0]   sh_sum;
  logic signed [SHOWN_W-1:0]  shown_nxt;
  logic                       out_load;

  assign pop_ready   = (state_r == ST_IDLE);
  assign stat.busy   = (state_r != ST_IDLE);
  assign out_load    = (state_r == ST_OUT) && (!out_valid_r || out_if.ready);

  assign out_if.valid            = out_valid_r;
  assign out_if.net_counts       = out_net_r;
  assign out_if.weight           = out_weight_r;
  assign out_if.filtered_weight  = out_filt_r;
  assign out_if.shown_half_grams = out_shown_r;

  always_comb begin
    nmag_nxt = net_r[NB-1] ? $unsigned(-net_r) : $unsigned(net_r);
    smag_nxt = cfg.scale_factor[SCALE_W-1] ? $unsigned(-cfg.scale_factor)
                                           : $unsigned(cfg.scale_factor);

    // Round half away from zero on the magnitude, then saturate to 32 bits
    wsum = {1'b0, pmag_r} + W_BIAS;
    wmag = WM_W'(wsum >> SCALE_SHIFT);
    if (neg_r) begin
      weight_nxt = (wmag > WM_NEG_LIM) ? WEIGHT_MIN : $signed(-wmag[WEIGHT_W-1:0]);
    end else begin
      weight_nxt = (wmag > WM_POS_LIM) ? WEIGHT_MAX : $signed(wmag[WEIGHT_W-1:0]);
    end

    absw = weight_r[WEIGHT_W-1] ? $unsigned(-weight_r) : $unsigned(weight_r);
    absp = prev_r[WEIGHT_W-1] ? $unsigned(-prev_r) : $unsigned(prev_r);
    snap_nxt = (absw < WEIGHT_W'(cfg.zero_snap_limit)) ||
               ((absp > WEIGHT_W'(cfg.removal_prev_limit)) &&
                (absw < WEIGHT_W'(cfg.removal_now_limit)));

    // Signed round half away from zero: bias one less below zero
    gsum = gprod_r + (gprod_r[GP_W-1] ? G_BIAS_NEG : G_BIAS_POS);

    sh_sum    = (WEIGHT_W + 1)'(disp_r) + (disp_r[WEIGHT_W-1] ? SH_BIAS_NEG : SH_BIAS_POS);
    shown_nxt = SHOWN_W'(sh_sum >>> SHOWN_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tare_r      <= '0;
      disp_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (pop_valid) begin
            if (pop_is_tare) begin
              tare_r <= pop_raw;
              disp_r <= '0;
              prev_r <= '0;
            end else begin
              state_r <= ST_MAG;
            end
          end
        end
        ST_MAG:  state_r <= ST_MUL;
        ST_MUL:  state_r <= ST_SUM;
        ST_SUM:  state_r <= ST_WGT;
        ST_WGT:  state_r <= ST_DIF;
        ST_DIF: begin
          prev_r  <= weight_r;
          state_r <= ST_GMUL;
        end
        ST_GMUL: state_r <= ST_GRND;
        ST_GRND: state_r <= ST_UPD;
        ST_UPD: begin
          disp_r  <= snap_r ? '0 : WEIGHT_W'(Q_W'(disp_r) + q_r);
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      net_r <= NB'(pop_raw) - NB'(tare_r);
    end
    if (state_r == ST_MAG) begin
      nmag_r <= nmag_nxt;
      smag_r <= smag_nxt;
      neg_r  <= net_r[NB-1] ^ cfg.scale_factor[SCALE_W-1];
    end
    if (state_r == ST_MUL) begin
      plo_r <= nmag_r[LO_W-1:0] * smag_r;
      phi_r <= nmag_r[NB-1:LO_W] * smag_r;
    end
    if (state_r == ST_SUM) begin
      pmag_r <= PW'(plo_r) + (PW'(phi_r) << LO_W);
    end
    if (state_r == ST_WGT) begin
      weight_r <= weight_nxt;
    end
    if (state_r == ST_DIF) begin
      snap_r <= snap_nxt;
      diff_r <= DIFF_W'(weight_r) - DIFF_W'(disp_r);
    end
    if (state_r == ST_GMUL) begin
      gprod_r <= diff_r * $signed({1'b0, cfg.smoothing_gain});
    end
    if (state_r == ST_GRND) begin
      q_r <= Q_W'(gsum >>> GAIN_SHIFT);
    end
    if (out_load) begin
      out_net_r    <= NET_W'(net_r);
      out_weight_r <= weight_r;
      out_filt_r   <= disp_r;
      out_shown_r  <= shown_nxt;
    end
  end

endmodule

// File: rtl/core/load_cell_weight_filter_core.sv
// ----------------------------------------------------------------------------
// load_cell_weight_filter_core - tare, calibration and smoothing of readings
// A measure item runs through the back states MAG, MUL, SUM, WGT, DIF, GMUL, GRND,
// UPD and OUT, where it waits while an untaken result is held. One tare item per cycle
// while the back sequencer is idle; it works one item at a time and takes none while busy.
// Reset (sync, rst_n low): registers to defaults, tare and filter cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module load_cell_weight_filter_core import lcwf_pkg::*; #(
  parameter int SAMPLE_BITS      = 24,
  parameter int WEIGHT_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  lcwf_in_if.sink               in_if,
  lcwf_out_if.source            out_if
);

  cfg_t                          cfg_r;
  logic                          pop_valid;
  logic                          pop_ready;
  logic                          pop_is_tare;
  logic signed [SAMPLE_BITS-1:0] pop_raw;
  fr_stat_t                      fr_stat;
  bk_stat_t                      bk_stat;
  logic                          tare_pop;

  assign tare_pop = pop_valid && pop_ready && pop_is_tare;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_factor       <= SCALE_RST;
      cfg_r.zero_snap_limit    <= ZERO_SNAP_RST;
      cfg_r.removal_prev_limit <= REM_PREV_RST;
      cfg_r.removal_now_limit  <= REM_NOW_RST;
      cfg_r.smoothing_gain     <= GAIN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SCALE_FACTOR:       cfg_r.scale_factor       <= $signed(cfg_wdata[SCALE_W-1:0]);
        REG_ZERO_SNAP_LIMIT:    cfg_r.zero_snap_limit    <= cfg_wdata[LIMIT_W-1:0];
        REG_REMOVAL_PREV_LIMIT: cfg_r.removal_prev_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_REMOVAL_NOW_LIMIT:  cfg_r.removal_now_limit  <= cfg_wdata[LIMIT_W-1:0];
        REG_SMOOTHING_GAIN:     cfg_r.smoothing_gain     <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  lcwf_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_is_tare (pop_is_tare),
    .pop_raw     (pop_raw),
    .stat        (fr_stat)
  );

  lcwf_back #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_is_tare (pop_is_tare),
    .pop_raw     (pop_raw),
    .out_if      (out_if),
    .stat        (bk_stat)
  );

  // A tare item never produces a result
  `ASSERT_NEXT(a_tare_silent, tare_pop, !$rose(out_if.valid), "tare item produced a result")
  // Empty queue offers nothing to the back end
  `ASSERT_IMPLIES(a_empty_no_pop, fr_stat.empty, !pop_valid, "pop offered from empty queue")
  // Full queue back-pressures the input
  `ASSERT_IMPLIES(a_full_stalls, fr_stat.full, !in_if.ready, "input taken while queue full")
  // Results only come out of a running sequence
  `ASSERT_IMPLIES(a_result_busy, $rose(out_if.valid), $past(bk_stat.busy), "result without work")

endmodule
